/* rtl/cprm_pkg.sv */
// Shared types and constants for the column peak/RMS meter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package cprm_pkg;

  localparam int unsigned MAX_CHANNELS = 8;
  localparam int unsigned SAMPLE_BITS  = 16;
  localparam int unsigned CH_W         = 3;   // channel index
  localparam int unsigned CCNT_W       = 4;   // channel_count register
  localparam int unsigned FRM_W        = 16;  // frames_per_column register
  localparam int unsigned HGT_W        = 12;  // draw_height register
  localparam int unsigned CFG_W        = 16;  // widest register
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned SUM_W        = 51;
  localparam int unsigned RMS_W        = 11;
  localparam int unsigned ROW_W        = 13;
  localparam int unsigned N_W          = 19;  // frames * channels
  localparam int unsigned C2_W         = 2 * RMS_W;
  localparam int unsigned PROD_W       = C2_W + SUM_W;
  localparam int unsigned FS_SHIFT     = 2 * (SAMPLE_BITS - 1);
  localparam int unsigned Q_W          = PROD_W - FS_SHIFT;
  localparam int unsigned SQ_IN_W      = 2 * RMS_W;
  localparam int unsigned SQ_REM_W     = RMS_W + 2;
  localparam int unsigned CNT_W        = 6;
  localparam int unsigned MUL_STEPS    = C2_W;
  localparam int unsigned DIV_STEPS    = Q_W;
  localparam int unsigned SQRT_STEPS   = RMS_W;
  localparam int unsigned OUT_DATA_W   = 56;
  localparam int unsigned IN_DATA_W    = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAMES   = 2'd0,
    CFG_CHANNELS = 2'd1,
    CFG_MIX      = 2'd2,
    CFG_HEIGHT   = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_LOAD,
    ST_MUL,
    ST_DIV,
    ST_SQRT,
    ST_EMIT,
    ST_CLEAR
  } state_e;

  typedef struct packed {
    logic load;       // capture accepted sample
    logic acc;        // accumulate captured sample
    logic start;      // load one channel into the serial units
    logic mul_step;
    logic div_step;
    logic sqrt_step;
    logic emit;       // load output register, advance channel
    logic clear;      // clear accumulators after a column
  } cmd_t;

  typedef struct packed {
    logic col_end;    // current sample closes the column
    logic last_chan;  // channel being finished is the last drawn one
    logic out_free;   // output register can take a result
  } status_t;

endpackage

/* rtl/column_peak_rms_meter.sv */
// Column peak/RMS meter: per-column sum of squares and peaks, RMS bar height.
// Each sample is captured, then accumulated; no new sample is taken before that is done.
// Column end: per drawn channel, load, shift-add multiply, restoring divide, square root
// and emit run in that order through the serial units, then a clear follows.
// Results leave through an output register; a full one holds the emit step.
// Reset rst_ni is asynchronous, active low; accumulators clear at once.
`timescale 1ns / 1ps

module column_peak_rms_meter
  import cprm_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration write port
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_W-1:0]        cfg_data_i,
  // sample stream
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [IN_DATA_W-1:0]    s_axis_tdata,   // [15:0] sample
  // result stream
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // [2:0] channel_index, [13:3] rms_half, [26:14] peak_top,
  // [39:27] peak_bottom, [50:40] max_rms, [55:51] zero
  output logic [OUT_DATA_W-1:0]   m_axis_tdata,
  output logic                    m_axis_tlast
);

  cmd_t    cmd;
  status_t st;

  // controller owns sequencing; the datapath does not decide anything
  cprm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_tvalid_i (s_axis_tvalid),
    .in_tready_o (s_axis_tready),
    .st_i        (st),
    .cmd_o       (cmd)
  );

  cprm_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .sample_i     (s_axis_tdata[SAMPLE_BITS-1:0]),
    .cmd_i        (cmd),
    .st_o         (st),
    .out_tvalid_o (m_axis_tvalid),
    .out_tready_i (m_axis_tready),
    .out_tdata_o  (m_axis_tdata),
    .out_tlast_o  (m_axis_tlast)
  );

  // never overwrite a result that is still waiting
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> st.out_free)
    else $error("result emitted into a full output register");

  // at most one command per cycle
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd))
    else $error("conflicting datapath commands");

  // an accepted sample is accumulated in the next cycle
  a_acc_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> cmd.acc)
    else $error("accepted sample not accumulated");

  // no sample is taken while a column is being finished
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.mul_step || cmd.div_step || cmd.sqrt_step) |-> !s_axis_tready)
    else $error("sample accepted during column computation");

endmodule

/* rtl/cprm_ctrl.sv */
// Sequencer for the column peak/RMS meter.
// Depends on cprm_pkg; drives cmd_t to the datapath, reads status_t.
`timescale 1ns / 1ps

module cprm_ctrl
  import cprm_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_tvalid_i,
  output logic    in_tready_o,
  input  status_t st_i,
  output cmd_t    cmd_o
);

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmd_o       = '0;
    in_tready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_tready_o = 1'b1;
        if (in_tvalid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd_o.acc = 1'b1;
        state_d   = st_i.col_end ? ST_LOAD : ST_IDLE;
      end
      ST_LOAD: begin
        cmd_o.start = 1'b1;
        cnt_d       = CNT_W'(MUL_STEPS - 1);
        state_d     = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul_step = 1'b1;
        cnt_d          = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          cnt_d   = CNT_W'(DIV_STEPS - 1);
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          cnt_d   = CNT_W'(SQRT_STEPS - 1);
          state_d = ST_SQRT;
        end
      end
      ST_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        cnt_d           = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (st_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = st_i.last_chan ? ST_CLEAR : ST_LOAD;
        end
      end
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/cprm_dp.sv */
// Datapath of the column peak/RMS meter: config registers, accumulators,
// serial multiply / divide / square-root units and the output register.
// Depends on cprm_pkg; commanded by cprm_ctrl.
`timescale 1ns / 1ps

module cprm_dp
  import cprm_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0]           cfg_data_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  cmd_t                       cmd_i,
  output status_t                    st_o,
  output logic                       out_tvalid_o,
  input  logic                       out_tready_i,
  output logic [OUT_DATA_W-1:0]      out_tdata_o,
  output logic                       out_tlast_o
);

  // configuration
  logic [FRM_W-1:0]  frames_q;
  logic [CCNT_W-1:0] chans_q;
  logic              mix_q;
  logic [HGT_W-1:0]  height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_q <= FRM_W'(1);
      chans_q  <= CCNT_W'(1);
      mix_q    <= 1'b0;
      height_q <= HGT_W'(120);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_FRAMES:   frames_q <= cfg_data_i[FRM_W-1:0];
        CFG_CHANNELS: chans_q  <= cfg_data_i[CCNT_W-1:0];
        CFG_MIX:      mix_q    <= cfg_data_i[0];
        CFG_HEIGHT:   height_q <= cfg_data_i[HGT_W-1:0];
        default:      ;
      endcase
    end
  end

  logic [CCNT_W-1:0] chans_eff;
  logic [FRM_W-1:0]  frames_eff;
  logic [RMS_W-1:0]  center;
  logic [CH_W-1:0]   last_idx;

  always_comb begin
    if (chans_q == '0) begin
      chans_eff = CCNT_W'(1);
    end else if (chans_q > CCNT_W'(MAX_CHANNELS)) begin
      chans_eff = CCNT_W'(MAX_CHANNELS);
    end else begin
      chans_eff = chans_q;
    end
    frames_eff = (frames_q == '0) ? FRM_W'(1) : frames_q;
    center     = height_q[HGT_W-1:1];
    last_idx   = mix_q ? '0 : CH_W'(chans_eff - 1'b1);
  end

  // accumulators
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic [SUM_W-1:0]              sums_q [MAX_CHANNELS];
  logic signed [SAMPLE_BITS-1:0] ppk_q  [MAX_CHANNELS];
  logic signed [SAMPLE_BITS-1:0] npk_q  [MAX_CHANNELS];
  logic [CH_W-1:0]               cpos_q;
  logic [FRM_W-1:0]              fpos_q;
  logic [CH_W-1:0]               ch_q;

  logic [CH_W-1:0]               grp;
  logic [CH_W-1:0]               rd_idx;
  logic [SUM_W-1:0]              rd_sum;
  logic signed [SAMPLE_BITS-1:0] rd_ppk, rd_npk;
  logic [SAMPLE_BITS-1:0]        mag;
  logic [2*SAMPLE_BITS-1:0]      mag_sq;
  logic [CCNT_W-1:0]             cpos_inc;
  logic                          wrap;
  logic [FRM_W:0]                fpos_inc;

  always_comb begin
    grp      = mix_q ? '0 : cpos_q;
    rd_idx   = cmd_i.acc ? grp : ch_q;
    rd_sum   = sums_q[rd_idx];
    rd_ppk   = ppk_q[rd_idx];
    rd_npk   = npk_q[rd_idx];
    mag      = sample_q[SAMPLE_BITS-1] ? SAMPLE_BITS'(-sample_q) : SAMPLE_BITS'(sample_q);
    mag_sq   = mag * mag;
    cpos_inc = CCNT_W'(cpos_q) + 1'b1;
    wrap     = cpos_inc >= chans_eff;
    fpos_inc = (FRM_W+1)'(fpos_q) + (FRM_W+1)'(wrap);
    st_o.col_end = wrap && (fpos_inc >= (FRM_W+1)'(frames_eff));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sample_q <= sample_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        sums_q[i] <= '0;
        ppk_q[i]  <= '0;
        npk_q[i]  <= '0;
      end
      cpos_q <= '0;
      fpos_q <= '0;
      ch_q   <= '0;
    end else if (cmd_i.clear) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        sums_q[i] <= '0;
        ppk_q[i]  <= '0;
        npk_q[i]  <= '0;
      end
      fpos_q <= '0;
      ch_q   <= '0;
    end else begin
      if (cmd_i.acc) begin
        sums_q[grp] <= rd_sum + SUM_W'(mag_sq);
        if (sample_q > rd_ppk) ppk_q[grp] <= sample_q;
        if (sample_q < rd_npk) npk_q[grp] <= sample_q;
        cpos_q <= wrap ? '0 : CH_W'(cpos_inc);
        fpos_q <= fpos_inc[FRM_W-1:0];
      end
      if (cmd_i.emit) begin
        ch_q <= ch_q + 1'b1;
      end
    end
  end

  // serial units: shift-add c^2*S, restoring divide by n, digit square root
  logic [PROD_W-1:0]   prod_q, ma_q;
  logic [C2_W-1:0]     mb_q;
  logic [N_W-1:0]      n_q, rem_q;
  logic [RMS_W-1:0]    root_q;
  logic [SQ_REM_W-1:0] srem_q;
  logic [Q_W-1:0]      quo;
  logic [N_W:0]        trial;
  logic                dge;
  logic [SQ_REM_W+1:0] srem2, strial;
  logic                sge;

  always_comb begin
    quo    = prod_q[PROD_W-1:FS_SHIFT];
    trial  = {rem_q, quo[Q_W-1]};
    dge    = trial >= (N_W+1)'(n_q);
    srem2  = {srem_q, prod_q[FS_SHIFT+SQ_IN_W-1 -: 2]};
    strial = (SQ_REM_W+2)'({root_q, 2'b01});
    sge    = srem2 >= strial;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      prod_q <= '0;
      ma_q   <= PROD_W'(rd_sum);
      mb_q   <= center * center;
      n_q    <= N_W'(fpos_q) * N_W'(mix_q ? chans_eff : CCNT_W'(1));
      rem_q  <= '0;
      root_q <= '0;
      srem_q <= '0;
    end else if (cmd_i.mul_step) begin
      prod_q <= prod_q + (mb_q[0] ? ma_q : '0);
      ma_q   <= ma_q << 1;
      mb_q   <= mb_q >> 1;
    end else if (cmd_i.div_step) begin
      rem_q  <= dge ? N_W'(trial - (N_W+1)'(n_q)) : trial[N_W-1:0];
      prod_q[PROD_W-1:FS_SHIFT] <= {quo[Q_W-2:0], dge};
    end else if (cmd_i.sqrt_step) begin
      srem_q <= sge ? SQ_REM_W'(srem2 - strial) : srem2[SQ_REM_W-1:0];
      root_q <= {root_q[RMS_W-2:0], sge};
      prod_q[FS_SHIFT+SQ_IN_W-1:FS_SHIFT] <=
        {prod_q[FS_SHIFT+SQ_IN_W-3:FS_SHIFT], 2'b00};
    end
  end

  // result assembly; quotient at or above 2^22 exceeds any center
  logic                       sat;
  logic [RMS_W-1:0]           rms;
  logic [RMS_W-1:0]           rms_max_q, rms_max_new;
  logic [SAMPLE_BITS-1:0]     pmag, nmag;
  logic [SAMPLE_BITS+HGT_W:0] ptop_p, pbot_p;
  logic [HGT_W-1:0]           top, bot;
  logic [ROW_W-1:0]           row_top, row_bot;

  always_comb begin
    sat         = |prod_q[PROD_W-1:FS_SHIFT+SQ_IN_W];
    rms         = (sat || root_q > center) ? center : root_q;
    rms_max_new = (rms > rms_max_q) ? rms : rms_max_q;
    pmag        = SAMPLE_BITS'(rd_ppk);
    nmag        = SAMPLE_BITS'(-rd_npk);
    ptop_p      = (SAMPLE_BITS+HGT_W+1)'(pmag) * (SAMPLE_BITS+HGT_W+1)'(height_q)
                  + (SAMPLE_BITS+HGT_W+1)'(1 << (SAMPLE_BITS-1));
    pbot_p      = (SAMPLE_BITS+HGT_W+1)'(nmag) * (SAMPLE_BITS+HGT_W+1)'(height_q)
                  + (SAMPLE_BITS+HGT_W+1)'(1 << (SAMPLE_BITS-1));
    top         = ptop_p[SAMPLE_BITS +: HGT_W];
    bot         = pbot_p[SAMPLE_BITS +: HGT_W];
    row_top     = ROW_W'(center) - ROW_W'(top);
    row_bot     = ROW_W'(center) + ROW_W'(bot);
    st_o.last_chan = ch_q == last_idx;
    st_o.out_free  = !out_tvalid_o || out_tready_i;
  end

  logic [OUT_DATA_W-1:0] odata_q;
  logic                  olast_q, ovalid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q  <= 1'b0;
      rms_max_q <= '0;
    end else begin
      if (cmd_i.emit) begin
        ovalid_q  <= 1'b1;
        rms_max_q <= rms_max_new;
      end else if (out_tready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      odata_q <= OUT_DATA_W'({rms_max_new, row_bot, row_top, rms, ch_q});
      olast_q <= st_o.last_chan;
    end
  end

  assign out_tvalid_o = ovalid_q;
  assign out_tdata_o  = odata_q;
  assign out_tlast_o  = olast_q;

endmodule
